@@ rtl/core/dhjq_pkg.sv @@
`timescale 1ns / 1ps

package dhjq_pkg;

  // CORDIC iteration count (valid range 12 to 30)
  localparam int CORDIC_STEPS = 24;
  // wrap stage, fold stage, iterations, sign and clamp stage
  localparam int CORDIC_LAT = CORDIC_STEPS + 3;

  localparam int NUM_COMP = 8;
  localparam int COMP_W = 3;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_THETA_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_OFFSET_D = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_LENGTH_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TWIST_ALPHA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JOINT_KIND = 3'd4;

  // angle constants in Q.30
  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [35:0] THREE_PI_Q30 = 36'sd10119778278;
  localparam logic signed [35:0] FOUR_PI_Q30 = 36'sd13493037704;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  // arctangent of 2^-i in Q.30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] r;
    unique case (idx)
      5'd0: r = 34'sh03243F6A8;
      5'd1: r = 34'sh01DAC6705;
      5'd2: r = 34'sh00FADBAFC;
      5'd3: r = 34'sh007F56EA6;
      5'd4: r = 34'sh003FEAB76;
      5'd5: r = 34'sh001FFD55B;
      5'd6: r = 34'sh000FFFAAA;
      5'd7: r = 34'sh0007FFF55;
      5'd8: r = 34'sh0003FFFEA;
      5'd9: r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;
      5'd11: r = 34'sh00007FFFF;
      5'd12: r = 34'sh00003FFFF;
      5'd13: r = 34'sh00001FFFF;
      5'd14: r = 34'sh00000FFFF;
      5'd15: r = 34'sh000007FFF;
      5'd16: r = 34'sh000003FFF;
      5'd17: r = 34'sh000001FFF;
      5'd18: r = 34'sh000000FFF;
      5'd19: r = 34'sh0000007FF;
      5'd20: r = 34'sh0000003FF;
      5'd21: r = 34'sh0000001FF;
      5'd22: r = 34'sh0000000FF;
      5'd23: r = 34'sh00000007F;
      5'd24: r = 34'sh00000003F;
      5'd25: r = 34'sh00000001F;
      5'd26: r = 34'sh00000000F;
      5'd27: r = 34'sh000000008;
      5'd28: r = 34'sh000000004;
      5'd29: r = 34'sh000000002;
      5'd30: r = 34'sh000000001;
      default: r = 34'sh000000000;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/dhjq_in_if.sv @@
`timescale 1ns / 1ps

interface dhjq_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] joint_position;

  modport source (output valid, output joint_position, input ready);
  modport sink (input valid, input joint_position, output ready);
endinterface

@@ rtl/core/dhjq_out_if.sv @@
`timescale 1ns / 1ps

interface dhjq_out_if;
  logic valid;
  logic ready;
  logic [dhjq_pkg::COMP_W-1:0] component_index;
  logic signed [31:0] pose_value;
  logic signed [31:0] derivative_value;
  logic last_component;

  modport source (output valid, output component_index, output pose_value,
                  output derivative_value, output last_component, input ready);
  modport sink (input valid, input component_index, input pose_value,
                input derivative_value, input last_component, output ready);
endinterface

@@ rtl/core/dhjq_cfg_if.sv @@
`timescale 1ns / 1ps

interface dhjq_cfg_if;
  logic valid;
  logic ready;
  logic [dhjq_pkg::CFG_IDX_W-1:0] index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/dh_joint_dual_quaternion_unit.sv @@
`timescale 1ns / 1ps
// The eight components of a request are handed out in order, one a cycle while the
// result port is ready. The CORDIC and product pipeline take a request every cycle
// unless a finished result waits for the result port, so a new joint position can be
// taken while the previous result is still being handed out.
// Reset (synchronous, active low) clears the joint registers to 0 and empties the pipeline.

module dh_joint_dual_quaternion_unit (
  input  logic clk,
  input  logic rst_n,
  dhjq_in_if.sink in_ch,
  dhjq_out_if.source out_ch,
  dhjq_cfg_if.sink cfg_ch
);

  localparam int LAT = dhjq_pkg::CORDIC_LAT;
  localparam int NC = dhjq_pkg::NUM_COMP;
  localparam int LS = LAT + 3;

  function automatic logic signed [31:0] mul_round(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [63:0] m;
    m = a * b + 64'sd536870912;
    return m[61:30];
  endfunction

  function automatic logic signed [64:0] mul_len(input logic signed [31:0] p,
                                                 input logic signed [32:0] l);
    logic signed [64:0] pe, le;
    pe = 65'(p);
    le = 65'(l);
    return pe * le;
  endfunction

  function automatic logic signed [31:0] prim(input logic signed [31:0] p,
                                              input logic ex);
    logic signed [32:0] v;
    v = 33'(p) + (ex ? 33'sd16384 : 33'sd8192);
    v = ex ? (v >>> 15) : (v >>> 14);
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fin(input logic signed [64:0] u,
                                             input logic su,
                                             input logic signed [64:0] w,
                                             input logic sw,
                                             input logic ex);
    logic signed [66:0] t, ue, we;
    ue = 67'(u);
    we = 67'(w);
    t = (su ? -ue : ue) + (sw ? -we : we);
    t = t + (ex ? (67'sd1 <<< 31) : (67'sd1 <<< 30));
    t = ex ? (t >>> 32) : (t >>> 31);
    if (t > 67'sd2147483647) t = 67'sd2147483647;
    if (t < -67'sd2147483648) t = -67'sd2147483648;
    return t[31:0];
  endfunction

  // configuration registers
  logic signed [31:0] theta_off_r, d_r, a_r, alpha_r;
  logic kind_r;

  logic en, load, last_beat;
  logic v_r [0:LS];

  logic signed [32:0] th_sum, dp_sum;
  logic signed [35:0] ht_r, ha_r;
  logic signed [32:0] dp_r [0:LAT];
  logic signed [31:0] ct, st, ca, sa;

  logic signed [31:0] pp_r [0:3];
  logic signed [31:0] dpp_r [0:3];
  logic signed [32:0] dpose_r;

  logic signed [64:0] pm_r [0:7];
  logic signed [64:0] dm_r [0:7];
  logic signed [31:0] ppri_r [0:3];
  logic signed [31:0] dpri_r [0:3];
  logic signed [32:0] der_d;
  logic signed [31:0] der_a;

  logic signed [31:0] spose_r [0:NC-1];
  logic signed [31:0] sder_r [0:NC-1];
  logic signed [31:0] bpose_r [0:NC-1];
  logic signed [31:0] bder_r [0:NC-1];
  logic busy_r;
  logic [dhjq_pkg::COMP_W-1:0] cnt_r;

  // register writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_off_r <= '0;
      d_r <= '0;
      a_r <= '0;
      alpha_r <= '0;
      kind_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dhjq_pkg::REG_THETA_OFFSET: theta_off_r <= cfg_ch.data;
        dhjq_pkg::REG_LINK_OFFSET_D: d_r <= cfg_ch.data;
        dhjq_pkg::REG_LINK_LENGTH_A: a_r <= cfg_ch.data;
        dhjq_pkg::REG_TWIST_ALPHA: alpha_r <= cfg_ch.data;
        dhjq_pkg::REG_JOINT_KIND: kind_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // advance the whole pipeline unless its last stage is blocked
  assign last_beat = busy_r && out_ch.ready && (cnt_r == dhjq_pkg::COMP_W'(NC - 1));
  assign load = v_r[LS] && (!busy_r || last_beat);
  assign en = !v_r[LS] || load;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= LS; j++) v_r[j] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_ch.valid;
      for (int j = 1; j <= LS; j++) v_r[j] <= v_r[j-1];
    end
  end

  // half angles and the pose offset d
  assign th_sum = 33'(theta_off_r) + (kind_r ? 33'sd0 : 33'(in_ch.joint_position));
  assign dp_sum = 33'(d_r) + (kind_r ? 33'(in_ch.joint_position) : 33'sd0);

  always_ff @(posedge clk) begin
    if (en) begin
      ht_r <= {th_sum[32], th_sum[32], th_sum, 1'b0};
      ha_r <= {alpha_r[31], alpha_r[31], alpha_r[31], alpha_r, 1'b0};
      dp_r[0] <= dp_sum;
      for (int j = 1; j <= LAT; j++) dp_r[j] <= dp_r[j-1];
    end
  end

  dhjq_cordic u_cordic_theta (
    .clk     (clk),
    .en      (en),
    .angle_i (ht_r),
    .cos_o   (ct),
    .sin_o   (st)
  );

  dhjq_cordic u_cordic_alpha (
    .clk     (clk),
    .en      (en),
    .angle_i (ha_r),
    .cos_o   (ca),
    .sin_o   (sa)
  );

  // trig products: pose uses (cos, sin), revolute derivative uses (-sin, cos)
  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= mul_round(ct, ca);
      pp_r[1] <= mul_round(ct, sa);
      pp_r[2] <= mul_round(st, sa);
      pp_r[3] <= mul_round(st, ca);
      dpp_r[0] <= mul_round(kind_r ? ct : -st, ca);
      dpp_r[1] <= mul_round(kind_r ? ct : -st, sa);
      dpp_r[2] <= mul_round(kind_r ? st : ct, sa);
      dpp_r[3] <= mul_round(kind_r ? st : ct, ca);
      dpose_r <= dp_r[LAT];
    end
  end

  // length products and primary parts
  assign der_d = kind_r ? 33'sd65536 : 33'(d_r);
  assign der_a = kind_r ? 32'sd0 : a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pm_r[0] <= mul_len(pp_r[3], dpose_r);
      pm_r[1] <= mul_len(pp_r[1], 33'(a_r));
      pm_r[2] <= mul_len(pp_r[2], dpose_r);
      pm_r[3] <= mul_len(pp_r[0], 33'(a_r));
      pm_r[4] <= mul_len(pp_r[3], 33'(a_r));
      pm_r[5] <= mul_len(pp_r[1], dpose_r);
      pm_r[6] <= mul_len(pp_r[0], dpose_r);
      pm_r[7] <= mul_len(pp_r[2], 33'(a_r));
      dm_r[0] <= mul_len(dpp_r[3], der_d);
      dm_r[1] <= mul_len(dpp_r[1], 33'(der_a));
      dm_r[2] <= mul_len(dpp_r[2], der_d);
      dm_r[3] <= mul_len(dpp_r[0], 33'(der_a));
      dm_r[4] <= mul_len(dpp_r[3], 33'(der_a));
      dm_r[5] <= mul_len(dpp_r[1], der_d);
      dm_r[6] <= mul_len(dpp_r[0], der_d);
      dm_r[7] <= mul_len(dpp_r[2], 33'(der_a));
      for (int k = 0; k < 4; k++) begin
        ppri_r[k] <= prim(pp_r[k], 1'b0);
        dpri_r[k] <= kind_r ? 32'sd0 : prim(dpp_r[k], 1'b1);
      end
    end
  end

  // dual parts: sum, round and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        spose_r[k] <= ppri_r[k];
        sder_r[k] <= dpri_r[k];
      end
      spose_r[4] <= fin(pm_r[0], 1'b1, pm_r[1], 1'b1, 1'b0);
      spose_r[5] <= fin(pm_r[2], 1'b1, pm_r[3], 1'b0, 1'b0);
      spose_r[6] <= fin(pm_r[4], 1'b0, pm_r[5], 1'b0, 1'b0);
      spose_r[7] <= fin(pm_r[6], 1'b0, pm_r[7], 1'b1, 1'b0);
      sder_r[4] <= fin(dm_r[0], 1'b1, dm_r[1], 1'b1, !kind_r);
      sder_r[5] <= fin(dm_r[2], 1'b1, dm_r[3], 1'b0, !kind_r);
      sder_r[6] <= fin(dm_r[4], 1'b0, dm_r[5], 1'b0, !kind_r);
      sder_r[7] <= fin(dm_r[6], 1'b0, dm_r[7], 1'b1, !kind_r);
    end
  end

  // hold eight components and hand them out one a cycle while the result port is ready
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < NC; k++) begin
        bpose_r[k] <= spose_r[k];
        bder_r[k] <= sder_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r <= '0;
    end else if (busy_r && out_ch.ready) begin
      if (last_beat) busy_r <= 1'b0;
      cnt_r <= cnt_r + dhjq_pkg::COMP_W'(1);
    end
  end

  assign out_ch.valid = busy_r;
  assign out_ch.component_index = cnt_r;
  assign out_ch.pose_value = bpose_r[cnt_r];
  assign out_ch.derivative_value = bder_r[cnt_r];
  assign out_ch.last_component = (cnt_r == dhjq_pkg::COMP_W'(NC - 1));

  // a run, once begun, continues without a gap in the buffer
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_component |=> out_ch.valid)
    else $error("result run broken before its last component");

  // components advance by one within a run
  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_component
    |=> out_ch.component_index == $past(out_ch.component_index) + 3'd1)
    else $error("component index skipped");

  // a run that directly follows a last component opens at component zero
  a_run_starts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_component
    |=> !out_ch.valid || out_ch.component_index == '0)
    else $error("run did not start at component zero");

endmodule

@@ rtl/core/dhjq_cordic.sv @@
`timescale 1ns / 1ps

module dhjq_cordic (
  input  logic clk,
  input  logic en,
  input  logic signed [35:0] angle_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int N = dhjq_pkg::CORDIC_STEPS;

  logic signed [35:0] w1_nxt, w1_r;
  logic signed [35:0] w2;
  logic signed [35:0] fold;
  logic fold_neg;

  logic signed [33:0] x_r [0:N];
  logic signed [33:0] y_r [0:N];
  logic signed [33:0] z_r [0:N];
  logic neg_r [0:N];

  logic signed [33:0] xf, yf;

  // coarse wrap by two turns
  always_comb begin
    if (angle_i > dhjq_pkg::THREE_PI_Q30) begin
      w1_nxt = angle_i - dhjq_pkg::FOUR_PI_Q30;
    end else if (angle_i < -dhjq_pkg::THREE_PI_Q30) begin
      w1_nxt = angle_i + dhjq_pkg::FOUR_PI_Q30;
    end else begin
      w1_nxt = angle_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r <= w1_nxt;
    end
  end

  // fine wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    if (w1_r > dhjq_pkg::PI_Q30) begin
      w2 = w1_r - dhjq_pkg::TWO_PI_Q30;
    end else if (w1_r < -dhjq_pkg::PI_Q30) begin
      w2 = w1_r + dhjq_pkg::TWO_PI_Q30;
    end else begin
      w2 = w1_r;
    end
    if (w2 > dhjq_pkg::HALF_PI_Q30) begin
      fold = w2 - dhjq_pkg::PI_Q30;
      fold_neg = 1'b1;
    end else if (w2 < -dhjq_pkg::HALF_PI_Q30) begin
      fold = w2 + dhjq_pkg::PI_Q30;
      fold_neg = 1'b1;
    end else begin
      fold = w2;
      fold_neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= dhjq_pkg::CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= fold[33:0];
      neg_r[0] <= fold_neg;
    end
  end

  // one rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - dhjq_pkg::atan_q30(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + dhjq_pkg::atan_q30(5'(i));
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // undo the fold and clamp to the unit range
  always_comb begin
    xf = neg_r[N] ? -x_r[N] : x_r[N];
    yf = neg_r[N] ? -y_r[N] : y_r[N];
    if (xf > dhjq_pkg::ONE_Q30) xf = dhjq_pkg::ONE_Q30;
    if (xf < -dhjq_pkg::ONE_Q30) xf = -dhjq_pkg::ONE_Q30;
    if (yf > dhjq_pkg::ONE_Q30) yf = dhjq_pkg::ONE_Q30;
    if (yf < -dhjq_pkg::ONE_Q30) yf = -dhjq_pkg::ONE_Q30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= xf[31:0];
      sin_o <= yf[31:0];
    end
  end

endmodule
